### rtl/assert_macros.svh
// Assertion shorthands for the checkers of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent in this cycle, consequent in the next.
`define R16_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Antecedent and consequent in the same cycle.
`define R16_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

### rtl/r16tm_pkg.sv
`default_nettype none

package r16tm_pkg;

  localparam int KEY_BITS      = 16;
  localparam int STRIDE_BITS   = 4;
  localparam int VALUE_BITS    = 32;
  localparam int NODE_POOL_DEF = 256;

  localparam int SLOTS   = 1 << STRIDE_BITS;
  localparam int LEVELS  = (KEY_BITS + STRIDE_BITS - 1) / STRIDE_BITS;
  localparam int KEY_PAD = LEVELS * STRIDE_BITS;
  localparam int LVL_W   = $clog2(LEVELS);

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_FIND   = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NULL      = 2'd1;
  localparam logic [1:0] ST_OCCUPIED  = 2'd2;
  localparam logic [1:0] ST_EXHAUSTED = 2'd3;

  typedef struct packed {
    logic [1:0]            op;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } req_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] result_value;
    logic [1:0]            status;
  } rsp_t;

  // sequencer status towards the top level
  typedef struct packed {
    logic idle;
    logic done;
  } stat_t;

endpackage

`default_nettype wire

### rtl/r16tm_ram.sv
`default_nettype none

module r16tm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/r16tm_ctrl.sv
`default_nettype none

module r16tm_ctrl #(
  parameter int NODE_POOL = r16tm_pkg::NODE_POOL_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire r16tm_pkg::req_t req,
  input  wire logic            take,
  output      r16tm_pkg::stat_t stat,
  output      r16tm_pkg::rsp_t res,
  output      logic            ram_we,
  output      logic [$clog2(NODE_POOL)+r16tm_pkg::STRIDE_BITS-1:0] ram_waddr,
  output      logic [((r16tm_pkg::VALUE_BITS > $clog2(NODE_POOL+1)) ?
                      r16tm_pkg::VALUE_BITS : $clog2(NODE_POOL+1))-1:0] ram_wdata,
  output      logic [$clog2(NODE_POOL)+r16tm_pkg::STRIDE_BITS-1:0] ram_raddr,
  input  wire logic [((r16tm_pkg::VALUE_BITS > $clog2(NODE_POOL+1)) ?
                      r16tm_pkg::VALUE_BITS : $clog2(NODE_POOL+1))-1:0] ram_rdata
);

  import r16tm_pkg::*;

  localparam int NODE_W  = $clog2(NODE_POOL);
  localparam int CNT_W   = $clog2(NODE_POOL + 1);
  localparam int ADDR_W  = NODE_W + STRIDE_BITS;
  localparam int STORE_W = (VALUE_BITS > CNT_W) ? VALUE_BITS : CNT_W;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_ROOT = 7'b0000010,
    S_READ = 7'b0000100,
    S_LOOK = 7'b0001000,
    S_ZERO = 7'b0010000,
    S_LINK = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t                  state;
  logic [CNT_W-1:0]        root [SLOTS];
  logic [CNT_W-1:0]        next_free;
  logic [1:0]              op;
  logic [KEY_PAD-1:0]      kres;
  logic [VALUE_BITS-1:0]   val;
  logic [VALUE_BITS-1:0]   result;
  logic [1:0]              status;
  logic [NODE_W-1:0]       node;
  logic [LVL_W-1:0]        depth;
  logic [STRIDE_BITS-1:0]  zcnt;
  logic                    par_root;
  logic [ADDR_W-1:0]       par_addr;

  logic [STRIDE_BITS-1:0]  frag;
  logic [STORE_W-1:0]      chk_link;
  logic                    link_ok;
  logic [NODE_W-1:0]       child;
  logic                    pool_full;
  logic [LVL_W-1:0]        depth_nxt;
  logic                    is_leaf;
  logic [CNT_W-1:0]        new_link;

  // shared link check: root slot in S_ROOT, node slot otherwise
  assign frag      = kres[KEY_PAD-1 -: STRIDE_BITS];
  assign chk_link  = (state == S_ROOT) ? STORE_W'(root[frag]) : ram_rdata;
  assign link_ok   = (chk_link != '0) && (chk_link <= STORE_W'(NODE_POOL));
  assign child     = NODE_W'(chk_link - STORE_W'(1));
  assign pool_full = (next_free == CNT_W'(NODE_POOL));
  assign depth_nxt = (state == S_ROOT) ? LVL_W'(1) : depth + LVL_W'(1);
  assign is_leaf   = (depth == LVL_W'(LEVELS - 1));
  assign new_link  = CNT_W'(node) + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      next_free <= '0;
      root      <= '{default: '0};
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            op     <= req.op;
            kres   <= KEY_PAD'(req.key);
            val    <= req.value;
            result <= '0;
            if (req.op == OP_CLEAR) begin
              status    <= ST_OK;
              root      <= '{default: '0};
              next_free <= '0;
              state     <= S_DONE;
            end else if (req.op == OP_INSERT && req.value == '0) begin
              status <= ST_NULL;
              state  <= S_DONE;
            end else begin
              status <= ST_OK;
              state  <= S_ROOT;
            end
          end
        end
        S_ROOT, S_LOOK: begin
          if (state == S_LOOK && is_leaf) begin
            case (op)
              OP_INSERT: begin
                if (ram_rdata != '0) begin
                  status <= ST_OCCUPIED;
                end
              end
              OP_REMOVE, OP_FIND: begin
                result <= ram_rdata[VALUE_BITS-1:0];
              end
              default: ;
            endcase
            state <= S_DONE;
          end else if (link_ok) begin
            node  <= child;
            depth <= depth_nxt;
            kres  <= kres << STRIDE_BITS;
            state <= S_READ;
          end else if (op != OP_INSERT) begin
            state <= S_DONE;
          end else if (pool_full) begin
            status <= ST_EXHAUSTED;
            state  <= S_DONE;
          end else begin
            par_root  <= (state == S_ROOT);
            par_addr  <= {node, frag};
            node      <= next_free[NODE_W-1:0];
            next_free <= next_free + CNT_W'(1);
            zcnt      <= '0;
            depth     <= depth_nxt;
            kres      <= kres << STRIDE_BITS;
            state     <= S_ZERO;
          end
        end
        S_ZERO: begin
          zcnt <= zcnt + STRIDE_BITS'(1);
          if (zcnt == '1) begin
            state <= S_LINK;
          end
        end
        S_LINK: begin
          if (par_root) begin
            root[par_addr[STRIDE_BITS-1:0]] <= new_link;
          end
          state <= S_READ;
        end
        S_READ: begin
          state <= S_LOOK;
        end
        S_DONE: begin
          if (take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // node store port
  always_comb begin
    ram_raddr = {node, frag};
    ram_we    = 1'b0;
    ram_waddr = {node, zcnt};
    ram_wdata = '0;
    case (state)
      S_ZERO: begin
        ram_we = 1'b1;
      end
      S_LINK: begin
        ram_we    = !par_root;
        ram_waddr = par_addr;
        ram_wdata = STORE_W'(new_link);
      end
      S_LOOK: begin
        if (is_leaf) begin
          ram_waddr = {node, frag};
          case (op)
            OP_INSERT: begin
              ram_we    = (ram_rdata == '0);
              ram_wdata = STORE_W'(val);
            end
            OP_REMOVE: begin
              ram_we = 1'b1;
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  assign stat.idle         = (state == S_IDLE);
  assign stat.done         = (state == S_DONE);
  assign res.result_value  = result;
  assign res.status        = status;

endmodule

`default_nettype wire

### rtl/radix16_trie_map.sv
`default_nettype none

// Sparse map from 16-bit keys to nonzero 32-bit values, kept as a four-level
// trie of 16-slot nodes indexed by key nibbles, top nibble first. The root
// node sits in flip-flops; deeper nodes come from a pool of NODE_POOL nodes
// in one node store RAM, handed out in order and zeroed as they are handed
// out (nothing is freed until a clear). Ops: insert, remove, find, clear.
// One item at a time: req_stall is high from acceptance until the result
// has gone into the response register. A walk does one root lookup, then a
// read and a check per deeper level through the single RAM read port with
// its registered output. Every node allocated on an insert adds 16 zeroing
// writes through the one RAM write port plus the link write. Clear and a
// rejected null insert skip the walk and answer straight from acceptance.
// No clearing pass is needed after reset. The response register lets the
// next item be accepted while a finished response still waits for
// rsp_stall to drop.

module radix16_trie_map #(
  parameter int NODE_POOL = r16tm_pkg::NODE_POOL_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output      logic            req_stall,
  input  wire r16tm_pkg::req_t req,
  output      logic            rsp_valid,
  input  wire logic            rsp_stall,
  output      r16tm_pkg::rsp_t rsp
);

  import r16tm_pkg::*;

  localparam int NODE_W  = $clog2(NODE_POOL);
  localparam int CNT_W   = $clog2(NODE_POOL + 1);
  localparam int ADDR_W  = NODE_W + STRIDE_BITS;
  localparam int STORE_W = (VALUE_BITS > CNT_W) ? VALUE_BITS : CNT_W;

  stat_t              stat;
  rsp_t               res;
  logic               start;
  logic               take;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [STORE_W-1:0] ram_wdata;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [STORE_W-1:0] ram_rdata;

  // busy for the whole walk
  assign req_stall = !stat.idle;
  assign start     = req_valid && !req_stall;

  // finished item moves on once the response register is free or emptying
  assign take = stat.done && (!rsp_valid || !rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (take) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rsp <= res;
    end
  end

  r16tm_ctrl #(
    .NODE_POOL (NODE_POOL)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req       (req),
    .take      (take),
    .stat      (stat),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // node store: one entry per slot of every pool node
  r16tm_ram #(
    .WIDTH (STORE_W),
    .DEPTH (NODE_POOL * SLOTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

### rtl/r16tm_checker.sv
`default_nettype none

`include "assert_macros.svh"

module r16tm_checker (
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            req_valid,
  input wire logic            req_stall,
  input wire logic            rsp_valid,
  input wire logic            rsp_stall,
  input wire r16tm_pkg::rsp_t rsp
);

  // response held while stalled
  `R16_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "response dropped or changed while stalled")

  // one item at a time: busy right after an accept
  `R16_ASSERT_NEXT(a_busy_after_accept, clk, rst, req_valid && !req_stall, req_stall, "request side not busy after accepting an item")

  // a new response only comes out of a walk in progress
  `R16_ASSERT_SAME(a_rsp_from_walk, clk, rst, $rose(rsp_valid), $past(req_stall), "response appeared with no item in progress")

endmodule

bind radix16_trie_map r16tm_checker u_r16tm_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

`default_nettype wire

### sim/radix16_trie_map_tb.sv
`timescale 1ns / 100ps

module radix16_trie_map_tb;
  import r16tm_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int MAX_WAIT     = 13;
  localparam int POOL         = NODE_POOL_DEF;
  localparam int SETTLE       = 64;   // longer than the longest insert
  localparam int RECENT_DEPTH = 24;
  localparam int PHASES       = 11;
  localparam int PHASE_ITEMS  = 100;

  // one outstanding item: the request as accepted and the response it owes
  typedef struct {
    req_t req;
    rsp_t rsp;
  } owed_rsp_t;

  // Shadow copy of the trie. Node numbers, links and the bump pointer are
  // kept exactly as the block keeps them, so exhaustion and half-built
  // paths fall out of the same walk.
  class trie_scoreboard;
    logic [8:0]  root_link [SLOTS];
    logic [31:0] node_mem [POOL*SLOTS];
    int unsigned nodes_used;
    owed_rsp_t   owed [$];
    int unsigned failures;

    function new();
      foreach (root_link[i]) root_link[i] = '0;
      foreach (node_mem[i]) node_mem[i] = '0;
      nodes_used = 0;
      failures   = 0;
    endfunction

    // Walks to the leaf slot of key; with grow set, missing nodes are taken
    // from the pool on the way. Returns 0 on a missing path or a dry pool.
    function bit leaf_index(logic [KEY_BITS-1:0] key, bit grow, output int unsigned idx);
      logic [31:0] link;
      logic [3:0]  nib;
      int unsigned base;
      int          d;
      int          s;
      base = 0;
      idx  = 0;
      for (d = 0; d < LEVELS-1; d++) begin
        nib  = 4'(key >> (STRIDE_BITS*(LEVELS-1-d)));
        link = (d == 0) ? {23'b0, root_link[nib]} : node_mem[base + nib];
        // out-of-range link counts as empty
        if (link == 0 || link > POOL) begin
          if (!grow || nodes_used >= POOL) return 1'b0;
          for (s = 0; s < SLOTS; s++) node_mem[nodes_used*SLOTS + s] = '0;
          nodes_used++;
          link = nodes_used;
          if (d == 0) root_link[nib] = link[8:0];
          else node_mem[base + nib] = link;
        end
        base = (link - 1) * SLOTS;
      end
      idx = base + (key & (SLOTS-1));
      return 1'b1;
    endfunction

    function void note_request(req_t r);
      owed_rsp_t   e;
      int unsigned idx;
      e.req = r;
      e.rsp.result_value = '0;
      e.rsp.status = ST_OK;
      case (r.op)
        OP_INSERT: begin
          if (r.value == '0) e.rsp.status = ST_NULL;
          else if (!leaf_index(r.key, 1'b1, idx)) e.rsp.status = ST_EXHAUSTED;
          else if (node_mem[idx] != '0) e.rsp.status = ST_OCCUPIED;
          else node_mem[idx] = r.value;
        end
        OP_REMOVE: begin
          if (leaf_index(r.key, 1'b0, idx)) begin
            e.rsp.result_value = node_mem[idx];
            node_mem[idx] = '0;
          end
        end
        OP_FIND: begin
          if (leaf_index(r.key, 1'b0, idx)) e.rsp.result_value = node_mem[idx];
        end
        default: begin
          foreach (root_link[i]) root_link[i] = '0;
          nodes_used = 0;
        end
      endcase
      owed.push_back(e);
    endfunction

    function void report(string msg);
      failures++;
      if (failures <= 10) $display("%s", msg);
    endfunction

    function void check_response(rsp_t got);
      owed_rsp_t e;
      if (owed.size() == 0) begin
        report($sformatf("unexpected response: value %h status %0d",
                         got.result_value, got.status));
        return;
      end
      e = owed.pop_front();
      if (got.result_value !== e.rsp.result_value || got.status !== e.rsp.status)
        report($sformatf("mismatch op %0d key %h value %h: exp %h/%0d got %h/%0d",
                         e.req.op, e.req.key, e.req.value, e.rsp.result_value,
                         e.rsp.status, got.result_value, got.status));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  trie_scoreboard sb;
  bit quiet;                              // phase with no idling on either side
  logic [KEY_BITS-1:0] recent_keys [$];   // keys recently inserted, for hits

  radix16_trie_map uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #10 clk = ~clk;

  function automatic int draw_wait();
    return quiet ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic req_t make_req(logic [1:0] op, logic [KEY_BITS-1:0] key,
                                    logic [VALUE_BITS-1:0] value);
    req_t r;
    r.op    = op;
    r.key   = key;
    r.value = value;
    return r;
  endfunction

  // Mostly keys that were inserted lately or their neighbours, so finds,
  // removes and occupied inserts actually land; the rest is random noise.
  function automatic req_t random_req();
    req_t r;
    int   pick;
    pick = $urandom_range(0, 99);
    if (recent_keys.size() > 0 && pick < 55) begin
      r.key = recent_keys[$urandom_range(0, recent_keys.size()-1)];
    end else if (recent_keys.size() > 0 && pick < 80) begin
      r.key = recent_keys[$urandom_range(0, recent_keys.size()-1)];
      r.key[3:0] = 4'($urandom);
      if ($urandom_range(0, 1) == 1) r.key[7:4] = 4'($urandom);
    end else begin
      r.key = KEY_BITS'($urandom);
    end
    r.value = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 42) begin
      r.op = OP_INSERT;
      pick = $urandom_range(0, 99);
      if (pick < 6) r.value = '0;
      else if (pick < 10) r.value = '1;
      recent_keys.push_back(r.key);
      if (recent_keys.size() > RECENT_DEPTH) void'(recent_keys.pop_front());
    end else if (pick < 70) begin
      r.op = OP_FIND;
    end else if (pick < 98) begin
      r.op = OP_REMOVE;
    end else begin
      r.op = OP_CLEAR;
    end
    return r;
  endfunction

  // Offers one item after a random gap and holds it until accepted. With a
  // zero gap valid simply stays high across items.
  task automatic send_item(req_t r);
    int gap;
    gap = draw_wait();
    @(negedge clk);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (req_stall);
    sb.note_request(r);
  endtask

  // Sender holds off until every owed response is back.
  task automatic drain();
    @(negedge clk);
    req_valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
  endtask

  // Response side: per item a random stall, then take the next response.
  initial begin : response_side
    int stall;
    rsp_stall = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        rsp_stall <= 1'b1;
        repeat (stall) @(negedge clk);
      end
      rsp_stall <= 1'b0;
      do @(posedge clk); while (!rsp_valid);
      sb.check_response(rsp);
      @(negedge clk);
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("** radix16_trie_map: FAILED **");
    $finish;
  end

  initial begin : request_side
    int i;
    int phase;
    sb        = new();
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    quiet     = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty map, extremes of key and value, null, occupied,
    // missing path, path present but leaf empty, remove twice, clear
    send_item(make_req(OP_FIND,   16'h0000, 32'h0000_0000));
    send_item(make_req(OP_REMOVE, 16'hFFFF, 32'hFFFF_FFFF));
    send_item(make_req(OP_INSERT, 16'h0000, 32'h0000_0000));
    send_item(make_req(OP_INSERT, 16'h0000, 32'hFFFF_FFFF));
    send_item(make_req(OP_INSERT, 16'hFFFF, 32'h0000_0001));
    send_item(make_req(OP_INSERT, 16'h0000, 32'h0000_0005));
    send_item(make_req(OP_FIND,   16'h0000, 32'h0000_0000));
    send_item(make_req(OP_FIND,   16'hFFFF, 32'h0000_0000));
    send_item(make_req(OP_FIND,   16'h0001, 32'h0000_0000));
    send_item(make_req(OP_FIND,   16'h1000, 32'h0000_0000));
    send_item(make_req(OP_REMOVE, 16'h0000, 32'h0000_0000));
    send_item(make_req(OP_REMOVE, 16'h0000, 32'h0000_0000));
    send_item(make_req(OP_FIND,   16'h0000, 32'h0000_0000));
    send_item(make_req(OP_INSERT, 16'h0000, 32'hA5A5_5A5A));
    send_item(make_req(OP_INSERT, 16'h8421, 32'h8000_0000));
    send_item(make_req(OP_CLEAR,  16'h5A5A, 32'hFFFF_FFFF));
    send_item(make_req(OP_FIND,   16'hFFFF, 32'h0000_0000));
    send_item(make_req(OP_INSERT, 16'hFFFF, 32'h0000_0000));
    send_item(make_req(OP_INSERT, 16'hFFFF, 32'h7FFF_FFFF));
    send_item(make_req(OP_FIND,   16'hFFFF, 32'h0000_0000));
    send_item(make_req(OP_CLEAR,  16'h0000, 32'h0000_0000));
    drain();

    // Pool fill: one key takes 3 nodes, then one more at the third level,
    // 15 more top nibbles at 3 each, then 2 each. That leaves a single node
    // when key 0x770x comes up, so its insert builds half a path and stops.
    send_item(make_req(OP_INSERT, 16'h0010, $urandom | 32'h1));
    for (i = 0; i < 130; i++)
      send_item(make_req(OP_INSERT, {i[3:0], i[7:4], 4'h0, 4'($urandom)},
                         $urandom | 32'h1));
    send_item(make_req(OP_FIND,   {8'h77, 4'h0, 4'($urandom)}, 32'h0));
    send_item(make_req(OP_INSERT, 16'h0015, 32'h1234_5678));   // existing path
    send_item(make_req(OP_INSERT, 16'h0016, 32'h0));
    send_item(make_req(OP_FIND,   16'h0015, 32'h0));
    send_item(make_req(OP_REMOVE, 16'h0015, 32'h0));
    send_item(make_req(OP_CLEAR,  16'hFFFF, 32'h0));
    drain();

    // random phases, one in four with no idling; drained between phases
    for (phase = 0; phase < PHASES; phase++) begin
      quiet = (phase % 4 == 2);
      for (i = 0; i < PHASE_ITEMS; i++) send_item(random_req());
      drain();
    end
    quiet = 1'b0;

    repeat (SETTLE) @(posedge clk);
    if (sb.failures == 0 && sb.owed.size() == 0)
      $display("** radix16_trie_map: PASSED **");
    else
      $display("** radix16_trie_map: FAILED **");
    $finish;
  end

endmodule
